[hw/rtl/rrqs_pkg.sv]
package rrqs_pkg;

   // Default number of entries in the ready queue.
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Field widths of the request and response items.
   localparam int PID_W   = 16;
   localparam int TIME_W  = 16;
   localparam int TICK_W  = 32;
   localparam int FIN_W   = 5;
   localparam int ENTRY_W = PID_W + 2 * TIME_W;

   // Quantum register reset value and its place in the register map.
   localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(100);
   localparam logic              REG_QUANTUM   = 1'b0;

   // Response status codes.
   typedef enum logic [2:0] {
      STATUS_REQUEUED = 3'd0,
      STATUS_FINISHED = 3'd1,
      STATUS_IDLE     = 3'd2,
      STATUS_ADDED    = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   // Request function codes.
   typedef enum logic {
      FUNC_ADD  = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic commit;    // execute the request and load the response register
   } cmd_type;

endpackage

[hw/rtl/rrqs_ctrl.sv]
module rrqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrqs_pkg::cmd_type cmd
);
   import rrqs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // The response register is free when empty or being drained this cycle.
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/rrqs_datapath.sv]
module rrqs_datapath #(
   parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rrqs_pkg::cmd_type                 cmd,
   input  logic [rrqs_pkg::TIME_W-1:0]       quantum,
   input  logic                              req_func,
   input  logic [rrqs_pkg::PID_W-1:0]        req_process_id,
   input  logic [rrqs_pkg::TIME_W-1:0]       req_burst_time,
   input  logic [rrqs_pkg::TIME_W-1:0]       req_io_time,
   output logic [2:0]                        rsp_status,
   output logic [rrqs_pkg::TICK_W-1:0]       rsp_tick_number,
   output logic [rrqs_pkg::PID_W-1:0]        rsp_dispatched_id,
   output logic [rrqs_pkg::TIME_W-1:0]       rsp_remaining_time,
   output logic [rrqs_pkg::TIME_W-1:0]       rsp_dispatched_io,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]  rsp_ready_count,
   output logic [rrqs_pkg::FIN_W-1:0]        rsp_finished_count
);
   import rrqs_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
   localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   // Ready queue storage: one entry holds {id, burst, io}.
   logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;

   // Captured request.
   logic              func_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [TIME_W-1:0] burst_ff;
   logic [TIME_W-1:0] io_ff;

   // Queue pointers and counters.
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [FIN_W-1:0]  done_ff, done_in;

   // Response register.
   status_type        status_ff, status_in;
   logic [TICK_W-1:0] out_tick_ff;
   logic [PID_W-1:0]  out_id_ff, out_id_in;
   logic [TIME_W-1:0] out_rem_ff, out_rem_in;
   logic [TIME_W-1:0] out_io_ff, out_io_in;
   logic [CW-1:0]     out_occ_ff;
   logic [FIN_W-1:0]  out_done_ff;

   // Head entry fields and quantum arithmetic.
   logic [PID_W-1:0]  head_id;
   logic [TIME_W-1:0] head_burst;
   logic [TIME_W-1:0] head_io;
   logic [TIME_W:0]   diff;
   logic              requeue;
   logic [CW:0]       tail_sum;
   logic [IW-1:0]     tail;

   assign {head_id, head_burst, head_io} = rd_data_ff;

   // A borrow or a zero difference means the burst fits in the quantum.
   assign diff    = {1'b0, head_burst} - {1'b0, quantum};
   assign requeue = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);

   // The tail slot is the same for an add and for a requeue after removal.
   assign tail_sum = {1'b0, (CW)'(head_ff)} + {1'b0, occ_ff};
   always_comb begin
      if (tail_sum >= DEPTH_EXT) tail = IW'(tail_sum - DEPTH_EXT);
      else                       tail = IW'(tail_sum);
   end

   // Execute the captured request.
   always_comb begin
      head_in    = head_ff;
      occ_in     = occ_ff;
      tick_in    = tick_ff;
      done_in    = done_ff;
      wr_en      = 1'b0;
      wr_data    = {pid_ff, burst_ff, io_ff};
      status_in  = STATUS_IDLE;
      out_id_in  = '0;
      out_rem_in = '0;
      out_io_in  = '0;
      if (func_ff == FUNC_ADD) begin
         if (occ_ff == DEPTH_CNT) begin
            status_in = STATUS_FULL;
         end else begin
            wr_en     = cmd.commit;
            occ_in    = occ_ff + CW'(1);
            status_in = STATUS_ADDED;
         end
      end else begin
         tick_in = tick_ff + TICK_W'(1);
         if (occ_ff != '0) begin
            head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + IW'(1);
            out_id_in = head_id;
            out_io_in = head_io;
            if (requeue) begin
               wr_en      = cmd.commit;
               wr_data    = {head_id, diff[TIME_W-1:0], head_io};
               out_rem_in = diff[TIME_W-1:0];
               status_in  = STATUS_REQUEUED;
            end else begin
               occ_in    = occ_ff - CW'(1);
               done_in   = done_ff + FIN_W'(1);
               status_in = STATUS_FINISHED;
            end
         end
      end
   end

   // Queue memory with a registered read of the head slot.
   always_ff @(posedge clock) begin
      if (wr_en) queue_mem[tail] <= wr_data;
      rd_data_ff <= queue_mem[head_ff];
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         pid_ff   <= req_process_id;
         burst_ff <= req_burst_time;
         io_ff    <= req_io_time;
      end
      if (cmd.commit) begin
         status_ff   <= status_in;
         out_tick_ff <= tick_in;
         out_id_ff   <= out_id_in;
         out_rem_ff  <= out_rem_in;
         out_io_ff   <= out_io_in;
         out_occ_ff  <= occ_in;
         out_done_ff <= done_in;
      end
   end

   // Queue pointers and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
         tick_ff <= '0;
         done_ff <= '0;
      end else if (cmd.commit) begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
         tick_ff <= tick_in;
         done_ff <= done_in;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_tick_number    = out_tick_ff;
   assign rsp_dispatched_id  = out_id_ff;
   assign rsp_remaining_time = out_rem_ff;
   assign rsp_dispatched_io  = out_io_ff;
   assign rsp_ready_count    = out_occ_ff;
   assign rsp_finished_count = out_done_ff;

endmodule

[hw/rtl/round_robin_quantum_scheduler_unit.sv]
// Round-robin process scheduler with a fixed time quantum. An add request
// appends a process to the ready queue (status added, or rejected when full);
// a tick request advances the tick counter and dispatches the front process,
// which is requeued with its burst reduced by the quantum or finishes (idle
// when the queue is empty). Every request is first accepted while the queue
// memory reads the head slot into its output register, then decided, with the
// tail slot written for an add or a requeue. A new request is accepted the
// cycle after the response is loaded; a response held by rsp_stall delays only
// the next commit. The queue holds QUEUE_DEPTH entries and needs no
// initialization after reset. The quantum register (reset 100) sits at address
// 0 and should be written only while the scheduler is idle.
module round_robin_quantum_scheduler_unit #(
   parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [rrqs_pkg::PID_W-1:0]        req_process_id,
   input  logic [rrqs_pkg::TIME_W-1:0]       req_burst_time,
   input  logic [rrqs_pkg::TIME_W-1:0]       req_io_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [rrqs_pkg::TICK_W-1:0]       rsp_tick_number,
   output logic [rrqs_pkg::PID_W-1:0]        rsp_dispatched_id,
   output logic [rrqs_pkg::TIME_W-1:0]       rsp_remaining_time,
   output logic [rrqs_pkg::TIME_W-1:0]       rsp_dispatched_io,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]  rsp_ready_count,
   output logic [rrqs_pkg::FIN_W-1:0]        rsp_finished_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import rrqs_pkg::*;

   cmd_type           cmd;
   logic [TIME_W-1:0] quantum_ff;
   logic              csr_hit;

   // Quantum register.
   assign csr_hit = (csr_paddr[2] == REG_QUANTUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         quantum_ff <= csr_pwdata[TIME_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {(32 - TIME_W)'(0), quantum_ff} : '0;

   rrqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rrqs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .quantum            (quantum_ff),
      .req_func           (req_func),
      .req_process_id     (req_process_id),
      .req_burst_time     (req_burst_time),
      .req_io_time        (req_io_time),
      .rsp_status         (rsp_status),
      .rsp_tick_number    (rsp_tick_number),
      .rsp_dispatched_id  (rsp_dispatched_id),
      .rsp_remaining_time (rsp_remaining_time),
      .rsp_dispatched_io  (rsp_dispatched_io),
      .rsp_ready_count    (rsp_ready_count),
      .rsp_finished_count (rsp_finished_count)
   );

`ifndef ASSERT_OFF
   // A request is never accepted and committed in the same cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

   // The reported queue occupancy never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ready_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("ready count above queue depth");

   // A finished process reports no remaining time.
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FINISHED)) |-> (rsp_remaining_time == '0))
      else $error("finished process with remaining time");

   // An idle tick only happens on an empty queue.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_IDLE)) |-> (rsp_ready_count == '0))
      else $error("idle tick with a nonempty queue");
`endif

endmodule
